// File: hw/rtl/r_type_alu_execute_macros.svh
// Assertion helpers for the R-type execute block.
`ifndef R_TYPE_ALU_EXECUTE_MACROS_SVH
`define R_TYPE_ALU_EXECUTE_MACROS_SVH

// Implication checked every clock, quiet while in reset.
`define RTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while in reset.
`define RTA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rta_pkg.sv
`default_nettype none
package rta_pkg;

    localparam int unsigned PcW = 30;

    typedef struct packed {
        logic [5:0]     primary_opcode;
        logic [5:0]     action;
        logic [4:0]     dest;
        logic [4:0]     shift_amount;
        logic [31:0]    value_s;
        logic [31:0]    value_t;
        logic [PcW-1:0] current_pc;
        logic [PcW-1:0] next_pc_in;
        logic           already_done;
    } t_in_item;

    typedef struct packed {
        logic           executed;
        logic           is_r_type;
        logic           is_jump;
        logic           reads_hi_lo;
        logic           starts_mul_div;
        logic [1:0]     fault;
        logic           write_enable;
        logic [4:0]     write_index;
        logic [31:0]    write_data;
        logic [PcW-1:0] next_pc_out;
    } t_out_item;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_JALR  = 6'h09;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_OVF   = 2'd1;
    localparam logic [1:0] FAULT_ALIGN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture input item
        logic exec;       // single-cycle evaluate
        logic mul_start;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic fix;        // sign fix and hi/lo write
        logic out_take;   // output transfer completed
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic last;       // iteration counter on final step
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/rta_ctrl.sv
`default_nettype none
module rta_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    input  rta_pkg::t_status i_status,
    output rta_pkg::t_cmd    o_cmd
);
    import rta_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.is_mul) begin
                    o_cmd.mul_start = 1'b1;
                    n_state         = ST_MUL;
                end else if (i_status.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.last) n_state = ST_FIX;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.last) n_state = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.out_take = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/rta_dp.sv
`default_nettype none
`include "r_type_alu_execute_macros.svh"
module rta_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  rta_pkg::t_in_item   i_in,
    input  wire [29:0]          i_jump_fault_target,
    input  rta_pkg::t_cmd       i_cmd,
    output rta_pkg::t_status    o_status,
    output rta_pkg::t_out_item  o_out
);
    import rta_pkg::*;

    t_in_item  r_in;
    t_out_item r_out, n_out;
    logic [31:0] r_hi, r_lo;
    logic [31:0] r_acc_hi, r_acc_lo;  // mul: product; div: remainder / quotient
    logic [31:0] r_opnd;              // mul multiplicand / div divisor (magnitude)
    logic [4:0]  r_cnt;
    logic        r_neg_q, r_neg_r, r_signed, r_skip;

    logic        active;
    logic [31:0] s, t, res, sum, dif, m_s, m_t;
    logic [4:0]  v;
    logic        known, adv, wr, is_md;
    logic [32:0] madd;
    logic [32:0] dtry;

    assign s      = r_in.value_s;
    assign t      = r_in.value_t;
    assign v      = s[4:0];
    assign sum    = s + t;
    assign dif    = s - t;
    assign active = !r_in.already_done && (r_in.primary_opcode == 6'd0);
    assign m_s    = (r_in.action == FN_MULT || r_in.action == FN_DIV) && s[31] ? -s : s;
    assign m_t    = (r_in.action == FN_MULT || r_in.action == FN_DIV) && t[31] ? -t : t;

    assign o_status.is_mul = active && (r_in.action == FN_MULT || r_in.action == FN_MULTU);
    assign o_status.is_div = active && (r_in.action == FN_DIV || r_in.action == FN_DIVU);
    assign o_status.last   = (r_cnt == 5'd31);

    always_comb begin
        known = 1'b1;
        adv   = 1'b1;
        wr    = 1'b1;
        is_md = 1'b0;
        res   = '0;
        n_out = '0;
        n_out.executed    = r_in.already_done;
        n_out.next_pc_out = r_in.next_pc_in;
        case (r_in.action)
            FN_SLL:  res = t << r_in.shift_amount;
            FN_SRL:  res = t >> r_in.shift_amount;
            FN_SRA:  res = 32'($signed(t) >>> r_in.shift_amount);
            FN_SLLV: res = t << v;
            FN_SRLV: res = t >> v;
            FN_SRAV: res = 32'($signed(t) >>> v);
            FN_JR: begin
                n_out.is_jump = 1'b1;
                wr  = 1'b0;
                adv = 1'b0;
                if (s[1:0] != 2'd0) n_out.fault = FAULT_ALIGN;
                else n_out.next_pc_out = s[31:2];
            end
            FN_JALR: begin
                n_out.is_jump = 1'b1;
                adv = 1'b0;
                res = {r_in.current_pc, 2'b00} + 32'd8;
                n_out.next_pc_out = (s[1:0] != 2'd0) ? i_jump_fault_target : s[31:2];
            end
            FN_MFHI: begin res = r_hi; n_out.reads_hi_lo = 1'b1; end
            FN_MTHI: wr = 1'b0;
            FN_MFLO: begin res = r_lo; n_out.reads_hi_lo = 1'b1; end
            FN_MTLO: wr = 1'b0;
            FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
                is_md = 1'b1;
                wr    = 1'b0;
            end
            FN_ADD: begin
                res = sum;
                if (!(s[31] ^ t[31]) && (s[31] ^ sum[31])) n_out.fault = FAULT_OVF;
            end
            FN_ADDU: res = sum;
            FN_SUB: begin
                res = dif;
                if ((s[31] ^ t[31]) && (s[31] ^ dif[31])) n_out.fault = FAULT_OVF;
            end
            FN_SUBU: res = dif;
            FN_AND:  res = s & t;
            FN_OR:   res = s | t;
            FN_XOR:  res = s ^ t;
            FN_SLT:  res = {31'd0, $signed(s) < $signed(t)};
            FN_SLTU: res = {31'd0, s < t};
            default: known = 1'b0;
        endcase
        if (n_out.fault != FAULT_NONE) wr = 1'b0;
        if (!active) begin
            n_out = '0;
            n_out.executed    = r_in.already_done;
            n_out.next_pc_out = r_in.next_pc_in;
        end else if (!known) begin
            n_out = '0;
            n_out.next_pc_out = r_in.next_pc_in;
        end else begin
            n_out.executed       = 1'b1;
            n_out.is_r_type      = 1'b1;
            n_out.starts_mul_div = is_md;
            if (n_out.fault == FAULT_NONE && adv) n_out.next_pc_out = r_in.next_pc_in + 30'd1;
            if (wr) begin
                n_out.write_enable = 1'b1;
                n_out.write_index  = r_in.dest;
                n_out.write_data   = res;
            end
        end
    end

    // Shift-add multiply step: acc_hi:acc_lo with multiplier in acc_lo.
    assign madd = {1'b0, r_acc_hi} + (r_acc_lo[0] ? {1'b0, r_opnd} : 33'd0);
    // Restoring divide step: remainder in acc_hi, dividend/quotient in acc_lo.
    assign dtry = {r_acc_hi, r_acc_lo[31]} - {1'b0, r_opnd};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.exec) r_out <= n_out;
        if (i_cmd.mul_start || i_cmd.div_start) begin
            r_cnt    <= 5'd0;
            r_opnd   <= i_cmd.mul_start ? m_s : m_t;
            r_acc_hi <= '0;
            r_acc_lo <= i_cmd.mul_start ? m_t : m_s;
            r_signed <= (r_in.action == FN_MULT) || (r_in.action == FN_DIV);
            r_neg_q  <= s[31] ^ t[31];
            r_neg_r  <= s[31];
            r_skip   <= i_cmd.div_start && (t == 32'd0);
        end
        if (i_cmd.mul_step) begin
            r_cnt    <= r_cnt + 5'd1;
            r_acc_hi <= madd[32:1];
            r_acc_lo <= {madd[0], r_acc_lo[31:1]};
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 5'd1;
            if (!dtry[32]) begin
                r_acc_hi <= dtry[31:0];
                r_acc_lo <= {r_acc_lo[30:0], 1'b1};
            end else begin
                r_acc_hi <= {r_acc_hi[30:0], r_acc_lo[31]};
                r_acc_lo <= {r_acc_lo[30:0], 1'b0};
            end
        end
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end else if (i_cmd.exec && active) begin
            if (r_in.action == FN_MTHI) r_hi <= s;
            if (r_in.action == FN_MTLO) r_lo <= s;
        end else if (i_cmd.fix) begin
            if (o_status.is_mul) begin
                if (r_signed && r_neg_q) {r_hi, r_lo} <= -{r_acc_hi, r_acc_lo};
                else {r_hi, r_lo} <= {r_acc_hi, r_acc_lo};
            end else if (!r_skip) begin
                r_lo <= (r_signed && r_neg_q) ? -r_acc_lo : r_acc_lo;
                r_hi <= (r_signed && r_neg_r) ? -r_acc_hi : r_acc_hi;
            end
        end
    end

    assign o_out = r_out;

    `RTA_ASSERT_NXT(a_fix_after_last, i_clk, i_rst_n,
        (i_cmd.mul_step || i_cmd.div_step) && o_status.last, i_cmd.fix, "fix must follow last step")
    `RTA_ASSERT_IMP(a_md_flag, i_clk, i_rst_n,
        i_cmd.mul_start || i_cmd.div_start, n_out.starts_mul_div, "md start without flag")
    `RTA_ASSERT_IMP(a_fault_nowrite, i_clk, i_rst_n,
        i_cmd.exec && n_out.fault != FAULT_NONE, !n_out.write_enable, "write on fault")

endmodule
`default_nettype wire

// File: hw/rtl/r_type_alu_execute.sv
// R-type execute block.
// Input channel: i_in_valid / o_in_stall carry one decoded instruction per
// transfer (t_in_item). Output channel: o_out_valid / i_out_stall carry one
// result per transfer (t_out_item). The block keeps hi and lo itself.
// One instruction is in flight at a time. Plain ALU, shift, jump and hi/lo
// moves offer their result after the execute state; mult, multu, div and
// divu then pass a 32-step shift-add / restoring-divide unit that does one
// bit a cycle, and a sign-fix state. The next input is taken the cycle after
// the result transfers. While the receiver stalls the result is held and the
// input stays stalled.
// Reset (i_rst_n low, synchronous) clears hi, lo, the jump fault target and
// the controller; no result is pending after reset.
// i_cfg_we writes jump_fault_target, the word index taken as next pc when
// a jalr target is misaligned; write it only while the block is idle.
`default_nettype none
`include "r_type_alu_execute_macros.svh"
module r_type_alu_execute (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  rta_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output rta_pkg::t_out_item  o_out_data,
    input  wire                 i_cfg_we,
    input  wire [29:0]          i_cfg_data
);
    import rta_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [29:0] r_jump_fault_target;

    // Hold the configured fault target; write only when idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_fault_target <= '0;
        end else if (i_cfg_we) begin
            r_jump_fault_target <= i_cfg_data;
        end
    end

    rta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rta_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in                (i_in_data),
        .i_jump_fault_target (r_jump_fault_target),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_out               (o_out_data)
    );

    // One instruction in flight: input never taken while a result is offered.
    `RTA_ASSERT_IMP(a_one_inflight, i_clk, i_rst_n, o_out_valid, o_in_stall, "input open with result")
    // A held result stays valid until it transfers.
    `RTA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped")
    // Load happens only on an input transfer.
    `RTA_ASSERT_IMP(a_load, i_clk, i_rst_n, cmd.load, i_in_valid && !o_in_stall, "load without transfer")

endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import rta_pkg::*;

    // Clock and reset.
    logic i_clk;
    logic i_rst_n;

    // Input channel, output channel, jump fault register port.
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_we;
    logic [29:0] i_cfg_data;

    r_type_alu_execute dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Predictor state: shadow hi/lo and the jump fault target.
    logic [31:0]    shadow_hi;
    logic [31:0]    shadow_lo;
    logic [PcW-1:0] shadow_jump_target;

    t_out_item pending_results[$];
    int        mismatch_count;
    int        result_count;
    int        item_count;
    int        cycle_count;
    bit        long_hold;      // receiver stays stalled while this is set
    bit        stall_enable;   // random receiver stalls on/off

    localparam int CYCLE_LIMIT = 800000;

    // Compute the result of one instruction and advance shadow hi/lo.
    function automatic t_out_item execute_instr(t_in_item it);
        t_out_item   r;
        logic        known;
        logic        advance;
        logic        wr;
        logic [31:0] res;
        logic [31:0] s;
        logic [31:0] t;
        logic [4:0]  v;
        logic [63:0] prod;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] q;
        logic [31:0] rm;
        s = it.value_s;
        t = it.value_t;
        v = s[4:0];
        r = '0;
        r.executed = it.already_done;
        r.fault = FAULT_NONE;
        r.next_pc_out = it.next_pc_in;
        if (!it.already_done && it.primary_opcode == 6'd0) begin
            known = 1'b1;
            advance = 1'b1;
            wr = 1'b1;
            res = '0;
            case (it.action)
                FN_SLL:  res = t << it.shift_amount;
                FN_SRL:  res = t >> it.shift_amount;
                FN_SRA:  res = $signed(t) >>> it.shift_amount;
                FN_SLLV: res = t << v;
                FN_SRLV: res = t >> v;
                FN_SRAV: res = $signed(t) >>> v;
                FN_JR: begin
                    r.is_jump = 1'b1;
                    wr = 1'b0;
                    advance = 1'b0;
                    if (s[1:0] != 2'b00) r.fault = FAULT_ALIGN;
                    else r.next_pc_out = s[31:2];
                end
                FN_JALR: begin
                    // Link is written even when the target is misaligned.
                    r.is_jump = 1'b1;
                    advance = 1'b0;
                    res = {it.current_pc, 2'b00} + 32'd8;
                    r.next_pc_out = (s[1:0] != 2'b00) ? shadow_jump_target : s[31:2];
                end
                FN_MFHI: begin
                    res = shadow_hi;
                    r.reads_hi_lo = 1'b1;
                end
                FN_MTHI: begin
                    shadow_hi = s;
                    wr = 1'b0;
                end
                FN_MFLO: begin
                    res = shadow_lo;
                    r.reads_hi_lo = 1'b1;
                end
                FN_MTLO: begin
                    shadow_lo = s;
                    wr = 1'b0;
                end
                FN_MULT: begin
                    prod = $signed({{32{s[31]}}, s}) * $signed({{32{t[31]}}, t});
                    {shadow_hi, shadow_lo} = prod;
                    r.starts_mul_div = 1'b1;
                    wr = 1'b0;
                end
                FN_MULTU: begin
                    prod = {32'd0, s} * {32'd0, t};
                    {shadow_hi, shadow_lo} = prod;
                    r.starts_mul_div = 1'b1;
                    wr = 1'b0;
                end
                FN_DIV: begin
                    // Divide by zero keeps hi/lo; most negative over -1 wraps.
                    if (t != 32'd0) begin
                        an = s[31] ? -s : s;
                        ad = t[31] ? -t : t;
                        q = an / ad;
                        rm = an % ad;
                        shadow_lo = (s[31] != t[31]) ? -q : q;
                        shadow_hi = s[31] ? -rm : rm;
                    end
                    r.starts_mul_div = 1'b1;
                    wr = 1'b0;
                end
                FN_DIVU: begin
                    if (t != 32'd0) begin
                        shadow_hi = s % t;
                        shadow_lo = s / t;
                    end
                    r.starts_mul_div = 1'b1;
                    wr = 1'b0;
                end
                FN_ADD: begin
                    res = s + t;
                    if (s[31] == t[31] && res[31] != s[31]) begin
                        r.fault = FAULT_OVF;
                        wr = 1'b0;
                    end
                end
                FN_ADDU: res = s + t;
                FN_SUB: begin
                    res = s - t;
                    if (s[31] != t[31] && res[31] != s[31]) begin
                        r.fault = FAULT_OVF;
                        wr = 1'b0;
                    end
                end
                FN_SUBU: res = s - t;
                FN_AND:  res = s & t;
                FN_OR:   res = s | t;
                FN_XOR:  res = s ^ t;
                FN_SLT:  res = ($signed(s) < $signed(t)) ? 32'd1 : 32'd0;
                FN_SLTU: res = (s < t) ? 32'd1 : 32'd0;
                default: known = 1'b0;
            endcase
            if (known) begin
                r.executed = 1'b1;
                r.is_r_type = 1'b1;
                if (r.fault == FAULT_NONE && advance) r.next_pc_out = it.next_pc_in + 1'b1;
                if (wr) begin
                    r.write_enable = 1'b1;
                    r.write_index = it.dest;
                    r.write_data = res;
                end
            end else begin
                r = '0;
                r.next_pc_out = it.next_pc_in;
            end
        end
        return r;
    endfunction

    // Drive one instruction and hold it until the block takes the transfer.
    task automatic send_instr(t_in_item it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(execute_instr(it));
        item_count++;
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        // Let any skip-type result still in flight surface.
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_jump_target(logic [29:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        shadow_jump_target = value;
    endtask

    function automatic logic [5:0] pick_action();
        logic [5:0] codes[25];
        codes = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
                  FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV,
                  FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
                  FN_XOR, FN_SLT, FN_SLTU};
        return codes[$urandom_range(24)];
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return $urandom_range(8);
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed R-type items, with some skip and unknown-code noise.
    function automatic t_in_item random_instr();
        t_in_item it;
        it.primary_opcode = ($urandom_range(15) == 0) ? 6'($urandom) : 6'd0;
        it.action = ($urandom_range(15) == 0) ? 6'($urandom) : pick_action();
        it.dest = 5'($urandom);
        it.shift_amount = 5'($urandom);
        it.value_s = pick_value();
        it.value_t = pick_value();
        it.current_pc = 30'($urandom);
        it.next_pc_in = ($urandom_range(9) == 0) ? 30'h3FFF_FFFF : 30'($urandom);
        it.already_done = ($urandom_range(15) == 0);
        return it;
    endfunction

    function automatic t_in_item make_instr(logic [5:0] fn, logic [31:0] s, logic [31:0] t);
        t_in_item it;
        it = '0;
        it.action = fn;
        it.dest = 5'd7;
        it.shift_amount = 5'd31;
        it.value_s = s;
        it.value_t = t;
        it.current_pc = 30'h3FFF_FFFF;
        it.next_pc_in = 30'h3FFF_FFFF;
        return it;
    endfunction

    // Compare every transfer on the output channel with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", o_out_data);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch #%0d: expected %p got %p",
                                 result_count, want, o_out_data);
                end
            end
        end
    end

    // Receiver: random stall pattern, with an optional long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else if (long_hold) i_out_stall <= 1'b1;
        else if (!stall_enable) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(3) == 0);
    end

    // Run timeout.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[r_type_alu_execute] ERROR");
            $finish;
        end
    end

    // Edge values for selected operations and each special case.
    task automatic test_directed();
        send_instr(make_instr(FN_ADD, 32'h7FFF_FFFF, 32'd1));     // add overflow
        send_instr(make_instr(FN_SUB, 32'h8000_0000, 32'd1));     // sub overflow
        send_instr(make_instr(FN_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_instr(make_instr(FN_SRAV, 32'hFFFF_FFE3, 32'h8000_0000)); // low 5 bits
        send_instr(make_instr(FN_SRA, 32'd0, 32'h8000_0001));
        send_instr(make_instr(FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF)); // wrap
        send_instr(make_instr(FN_MFHI, 32'd0, 32'd0));
        send_instr(make_instr(FN_MFLO, 32'd0, 32'd0));
        send_instr(make_instr(FN_DIVU, 32'd5, 32'd0));             // div by zero
        send_instr(make_instr(FN_DIV, 32'd5, 32'd0));
        send_instr(make_instr(FN_MFLO, 32'd0, 32'd0));
        send_instr(make_instr(FN_MULT, 32'h8000_0000, 32'h8000_0000));
        send_instr(make_instr(FN_MFHI, 32'd0, 32'd0));
        send_instr(make_instr(FN_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_instr(make_instr(FN_MTHI, 32'hA5A5_5A5A, 32'd0));
        send_instr(make_instr(FN_MTLO, 32'h5A5A_A5A5, 32'd0));
        send_instr(make_instr(FN_MFHI, 32'd0, 32'd0));
        send_instr(make_instr(FN_JR, 32'hFFFF_FFFE, 32'd0));      // misaligned jr
        send_instr(make_instr(FN_JR, 32'hFFFF_FFFC, 32'd0));
        send_instr(make_instr(FN_JALR, 32'h0000_0003, 32'd0));    // misaligned jalr
        send_instr(make_instr(FN_JALR, 32'hFFFF_FFFC, 32'd0));
        send_instr(make_instr(FN_SLT, 32'h8000_0000, 32'd0));
        send_instr(make_instr(FN_SLTU, 32'h8000_0000, 32'd0));
        send_instr(make_instr(6'h3F, 32'd1, 32'd1));              // unknown code
        begin
            t_in_item it;
            it = make_instr(FN_ADDU, 32'd1, 32'd1);
            it.already_done = 1'b1;
            send_instr(it);
            it.already_done = 1'b0;
            it.primary_opcode = 6'h3F;
            send_instr(it);
        end
        release_input();
    endtask

    // Random traffic sent in bursts with gaps.
    task automatic test_random(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(20, 1);
            repeat (burst) begin
                send_instr(random_instr());
                sent++;
            end
            if ($urandom_range(2) != 0) begin
                release_input();
                repeat ($urandom_range(6, 1)) @(posedge i_clk);
            end
        end
        release_input();
        @(posedge i_clk);
    endtask

    // Hold the receiver off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        fork
            begin
                long_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end
            test_random(40);
        join
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_out_stall = 1'b0;
        long_hold   = 1'b0;
        stall_enable = 1'b1;
        shadow_hi = '0;
        shadow_lo = '0;
        shadow_jump_target = '0;
        mismatch_count = 0;
        result_count = 0;
        item_count = 0;
        cycle_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        write_jump_target(30'h3FFF_FFFF);
        test_directed();
        wait_drained();
        write_jump_target(30'h1234_5678);
        stall_enable = 1'b0;
        test_random(400);   // stretch with no receiver stalls
        stall_enable = 1'b1;
        test_backpressure();
        wait_drained();      // sender pauses until everything is back
        write_jump_target(30'd0);
        test_random(800);
        wait_drained();
        write_jump_target(30'($urandom));
        test_random(700);
        wait_drained();

        $display("covered %0d instructions, %0d results, all codes, hi/lo and jump cases",
                 item_count, result_count);
        if (pending_results.size() != 0 || mismatch_count != 0) begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, pending_results.size());
            $display("[r_type_alu_execute] ERROR");
        end else begin
            $display("[r_type_alu_execute] OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rta_pkg.sv
hw/rtl/rta_ctrl.sv
hw/rtl/rta_dp.sv
hw/rtl/r_type_alu_execute.sv
bench/testbench.sv
